### sv/bq_pkg.sv
// ----------------------------------------------------------------------------
// Biquad filter package
// Widths, register indexes, multiply-accumulate control and delay saturation
// shared by the biquad filter and its multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bq_pkg;

   // Sample and coefficient formats.
   localparam int SAMPLE_WIDTH   = 24;
   localparam int COEF_FRAC_BITS = 20;
   localparam int COEF_W         = 24;
   localparam int DELAY_W        = 48;

   // Product of one coefficient and one sample, and the accumulator that sums
   // up to three terms of product or delay width without overflow.
   localparam int PROD_W = COEF_W + SAMPLE_WIDTH;
   localparam int ACC_W  = ((PROD_W > DELAY_W) ? PROD_W : DELAY_W) + 2;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_B0 = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_B1 = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_B2 = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_A1 = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_A2 = CSR_INDEX_W'(4);

   // Reset value of b0 is 1.0 in the coefficient format.
   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'sd1 <<< COEF_FRAC_BITS);

   // Limits of the signed delay range, at accumulator width.
   localparam logic signed [ACC_W-1:0] DELAY_MAX = ACC_W'((64'sd1 <<< (DELAY_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] DELAY_MIN = -DELAY_MAX - ACC_W'(1);

   // Control of the shared multiply-accumulate unit for one cycle.
   typedef struct packed {
      logic prod_en;   // register a new product
      logic acc_en;    // register the sum into the accumulator
      logic sub;       // sum is base minus product
   } mac_ctrl_type;

   // Saturate an accumulator value to the signed delay range.
   function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
      logic signed [DELAY_W-1:0] r;
      if (v > DELAY_MAX) begin
         r = DELAY_MAX[DELAY_W-1:0];
      end else if (v < DELAY_MIN) begin
         r = DELAY_MIN[DELAY_W-1:0];
      end else begin
         r = v[DELAY_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/biquad_filter_tdf2.sv
// ----------------------------------------------------------------------------
// Biquad filter, transposed direct form II
// Second-order IIR section with five programmable coefficients, rounded and
// saturated output, and saturated delay state.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on req_valid / req_stall with one signed sample each.
//   Each input item gives one result item on rsp_valid / rsp_stall carrying
//   the filtered sample and a flag that is set when it was saturated.
//   Coefficients b0, b1, b2, a1, a2 are written through csr_we, csr_index and
//   csr_wdata while the filter is idle; writes to other indexes are dropped.
//   The block works on one item at a time with a single registered multiplier
//   and one adder, issuing the five products in sequence. A new item is taken
//   only in the idle state, once the result of the last one has been stored.
//   The result sits in an output register, so the next item is accepted while
//   a result still waits. If the receiver stalls past the end of the next
//   item, that item holds in its last step until the output register frees.
//   Synchronous reset clears both delay values, sets b0 to 1.0 and the other
//   coefficients to zero, and drops any pending item or result.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_filter_tdf2 (
   input  wire                                         clock,
   input  wire                                         reset,
   input  wire                                         req_valid,
   output logic                                        req_stall,
   input  wire logic signed [bq_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                                        rsp_valid,
   input  wire                                         rsp_stall,
   output logic signed [bq_pkg::SAMPLE_WIDTH-1:0]      rsp_sample_out,
   output logic                                        rsp_clipped,
   input  wire                                         csr_we,
   input  wire logic [bq_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [bq_pkg::COEF_W-1:0]              csr_wdata
);

   localparam int SW    = bq_pkg::SAMPLE_WIDTH;
   localparam int AW    = bq_pkg::ACC_W;
   localparam int DW    = bq_pkg::DELAY_W;
   localparam int FRAC  = bq_pkg::COEF_FRAC_BITS;
   localparam int RND_W = AW + 1;

   localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(64'sd1 <<< (FRAC - 1));
   localparam logic signed [RND_W-1:0] Y_MAX    = RND_W'((64'sd1 <<< (SW - 1)) - 1);
   localparam logic signed [RND_W-1:0] Y_MIN    = -Y_MAX - RND_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,     // ready for an item
      ST_MUL_B0,   // product b0*x
      ST_ACC_D1,   // acc = d1 + b0*x, product b1*x
      ST_ROUND,    // y from acc, acc = d2 + b1*x
      ST_MUL_A1,   // product a1*y
      ST_SUB_A1,   // d1 = sat(acc - a1*y), product a2*y
      ST_NEG_A2,   // acc = -a2*y, product b2*x
      ST_STORE     // d2 = sat(acc + b2*x), result to output register
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic signed [bq_pkg::COEF_W-1:0] coef_b0_ff;
   logic signed [bq_pkg::COEF_W-1:0] coef_b1_ff;
   logic signed [bq_pkg::COEF_W-1:0] coef_b2_ff;
   logic signed [bq_pkg::COEF_W-1:0] coef_a1_ff;
   logic signed [bq_pkg::COEF_W-1:0] coef_a2_ff;

   logic signed [DW-1:0] delay_one_ff;
   logic signed [DW-1:0] delay_two_ff;
   logic signed [SW-1:0] x_ff;
   logic signed [SW-1:0] y_ff;
   logic                 clip_ff;

   logic                 rsp_valid_ff;
   logic signed [SW-1:0] rsp_sample_out_ff;
   logic                 rsp_clipped_ff;

   bq_pkg::mac_ctrl_type             mac_ctrl;
   logic signed [bq_pkg::COEF_W-1:0] mac_coef;
   logic signed [SW-1:0]             mac_sample;
   logic signed [AW-1:0]             mac_base;
   logic signed [AW-1:0]             mac_sum;
   logic signed [AW-1:0]             mac_acc;

   logic                 accept;
   logic                 out_free;
   logic signed [RND_W-1:0] rnd_sum;
   logic signed [RND_W-1:0] rnd_shift;
   logic signed [SW-1:0]    y_in;
   logic                    clip_in;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Round half up and saturate the accumulator to the sample range.
   assign rnd_sum   = {mac_acc[AW-1], mac_acc} + RND_HALF;
   assign rnd_shift = rnd_sum >>> FRAC;
   always_comb begin
      if (rnd_shift > Y_MAX) begin
         y_in    = Y_MAX[SW-1:0];
         clip_in = 1'b1;
      end else if (rnd_shift < Y_MIN) begin
         y_in    = Y_MIN[SW-1:0];
         clip_in = 1'b1;
      end else begin
         y_in    = rnd_shift[SW-1:0];
         clip_in = 1'b0;
      end
   end

   // Operand selection and next state for the sequencer.
   always_comb begin
      mac_ctrl   = '0;
      mac_coef   = coef_b0_ff;
      mac_sample = x_ff;
      mac_base   = '0;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL_B0;
            end
         end
         ST_MUL_B0: begin
            mac_ctrl.prod_en = 1'b1;
            state_in         = ST_ACC_D1;
         end
         ST_ACC_D1: begin
            mac_ctrl.prod_en = 1'b1;
            mac_ctrl.acc_en  = 1'b1;
            mac_coef         = coef_b1_ff;
            mac_base         = {{(AW - DW){delay_one_ff[DW-1]}}, delay_one_ff};
            state_in         = ST_ROUND;
         end
         ST_ROUND: begin
            mac_ctrl.acc_en = 1'b1;
            mac_base        = {{(AW - DW){delay_two_ff[DW-1]}}, delay_two_ff};
            state_in        = ST_MUL_A1;
         end
         ST_MUL_A1: begin
            mac_ctrl.prod_en = 1'b1;
            mac_coef         = coef_a1_ff;
            mac_sample       = y_ff;
            state_in         = ST_SUB_A1;
         end
         ST_SUB_A1: begin
            mac_ctrl.prod_en = 1'b1;
            mac_ctrl.acc_en  = 1'b1;
            mac_ctrl.sub     = 1'b1;
            mac_coef         = coef_a2_ff;
            mac_sample       = y_ff;
            mac_base         = mac_acc;
            state_in         = ST_NEG_A2;
         end
         ST_NEG_A2: begin
            mac_ctrl.prod_en = 1'b1;
            mac_ctrl.acc_en  = 1'b1;
            mac_ctrl.sub     = 1'b1;
            mac_coef         = coef_b2_ff;
            state_in         = ST_STORE;
         end
         ST_STORE: begin
            mac_base = mac_acc;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   bq_mac u_mac (
      .clock     (clock),
      .ctrl      (mac_ctrl),
      .op_coef   (mac_coef),
      .op_sample (mac_sample),
      .base      (mac_base),
      .sum       (mac_sum),
      .acc       (mac_acc)
   );

   // Coefficient registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= bq_pkg::COEF_ONE;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bq_pkg::CSR_B0: coef_b0_ff <= csr_wdata;
            bq_pkg::CSR_B1: coef_b1_ff <= csr_wdata;
            bq_pkg::CSR_B2: coef_b2_ff <= csr_wdata;
            bq_pkg::CSR_A1: coef_a1_ff <= csr_wdata;
            bq_pkg::CSR_A2: coef_a2_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sequencer state, delay state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            x_ff <= req_sample_in;
         end
         if (state_ff == ST_ROUND) begin
            y_ff    <= y_in;
            clip_ff <= clip_in;
         end
         if (state_ff == ST_SUB_A1) begin
            delay_one_ff <= bq_pkg::sat_delay(mac_sum);
         end
         // A new result replaces one that leaves; otherwise a taken one clears.
         if (state_ff == ST_STORE && out_free) begin
            delay_two_ff      <= bq_pkg::sat_delay(mac_sum);
            rsp_valid_ff      <= 1'b1;
            rsp_sample_out_ff <= y_ff;
            rsp_clipped_ff    <= clip_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_clipped    = rsp_clipped_ff;

`ifndef SYNTHESIS
   // An accepted item keeps the input side closed on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input accepted while an item is in progress");

   // A flagged result sits at one of the sample range limits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_sample_out == Y_MAX[SW-1:0] || rsp_sample_out == Y_MIN[SW-1:0]))
      else $error("clipped result not at a range limit");

   // A new result appears only out of the final sequencer step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_STORE))
      else $error("result raised outside the store step");
`endif

endmodule

`default_nettype wire

### sv/bq_mac.sv
// ----------------------------------------------------------------------------
// Biquad multiply-accumulate unit
// One registered signed multiplier followed by one add/subtract stage that
// combines the registered product with a base operand chosen by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bq_mac (
   input  wire                                        clock,
   input  wire bq_pkg::mac_ctrl_type                  ctrl,
   input  wire logic signed [bq_pkg::COEF_W-1:0]       op_coef,
   input  wire logic signed [bq_pkg::SAMPLE_WIDTH-1:0] op_sample,
   input  wire logic signed [bq_pkg::ACC_W-1:0]        base,
   output logic signed [bq_pkg::ACC_W-1:0]             sum,
   output logic signed [bq_pkg::ACC_W-1:0]             acc
);

   logic signed [bq_pkg::PROD_W-1:0] prod_in;
   logic signed [bq_pkg::PROD_W-1:0] prod_ff;
   logic signed [bq_pkg::ACC_W-1:0]  prod_ext;
   logic signed [bq_pkg::ACC_W-1:0]  acc_ff;

   // Full-precision product of coefficient and sample.
   assign prod_in = op_coef * op_sample;

   // Sign-extend the product and add it to or take it from the base.
   assign prod_ext = {{(bq_pkg::ACC_W - bq_pkg::PROD_W){prod_ff[bq_pkg::PROD_W-1]}}, prod_ff};
   assign sum      = ctrl.sub ? (base - prod_ext) : (base + prod_ext);
   assign acc      = acc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc_en) begin
         acc_ff <= sum;
      end
   end

endmodule

`default_nettype wire
